### src/clns_pkg.sv
// Shared types, constants and step tables for the character LCD nibble sequencer.
package clns_pkg;

  localparam int unsigned ROW_COUNT        = 4;
  localparam int unsigned POWER_UP_WAIT_US = 50000;
  localparam int unsigned CLEAR_WAIT_US    = 5000;

  localparam logic [15:0] PULSE_US    = 16'd2;
  localparam logic [15:0] INIT_GAP_US = 16'd200;
  localparam logic [15:0] BYTE_GAP_US = 16'd40;
  localparam int unsigned CLEAR_SUM   = 40 + CLEAR_WAIT_US;
  localparam logic [15:0] CLEAR_HOLD_US =
    (CLEAR_SUM > 65535) ? 16'hFFFF : CLEAR_SUM[15:0];
  localparam logic [15:0] POWER_UP_US = POWER_UP_WAIT_US[15:0];
  localparam logic [2:0]  ROW_LIMIT   = ROW_COUNT[2:0];

  localparam logic [3:0] PRE_LAST = 4'd9;
  localparam logic [2:0] SUB_LAST = 3'd4;
  localparam logic [1:0] SEL_LAST = 2'd3;

  typedef enum logic [3:0] {
    OP_INIT   = 4'd0,
    OP_CMD    = 4'd1,
    OP_DATA   = 4'd2,
    OP_MOVE   = 4'd3,
    OP_CLEAR  = 4'd4,
    OP_ON     = 4'd5,
    OP_CURSOR = 4'd6,
    OP_BLINK  = 4'd7,
    OP_DIR    = 4'd8,
    OP_SCROLL = 4'd9
  } clns_op_t;

  typedef enum logic [1:0] {
    CFG_FUNC  = 2'd0,
    CFG_DISP  = 2'd1,
    CFG_ENTRY = 2'd2
  } clns_cfg_t;

  typedef enum logic [1:0] {
    KIND_NONE,
    KIND_INIT,
    KIND_BYTE,
    KIND_BAD
  } clns_kind_t;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_PRE,
    ST_BYTE,
    ST_ERR
  } clns_state_t;

  typedef struct packed {
    logic       load;
    logic       emit;
    logic       pre;
    logic [3:0] pre_idx;
    logic [2:0] sub;
    logic [1:0] sel;
    logic       last;
    logic       err;
  } clns_cmd_t;

  typedef struct packed {
    logic       free;
    clns_kind_t kind;
  } clns_stat_t;

  typedef struct packed {
    logic        e;
    logic [3:0]  nib;
    logic [15:0] hold;
  } clns_pin_t;

  function automatic logic [6:0] row_base(input logic [1:0] idx);
    case (idx)
      2'd0:    row_base = 7'h00;
      2'd1:    row_base = 7'h40;
      2'd2:    row_base = 7'h10;
      default: row_base = 7'h50;
    endcase
  endfunction

  // power-up nibble sequence ahead of the four init bytes
  function automatic clns_pin_t pre_step(input logic [3:0] idx);
    clns_pin_t p;
    p = '{e: 1'b0, nib: 4'd3, hold: PULSE_US};
    case (idx)
      4'd0:    p = '{e: 1'b0, nib: 4'd0, hold: POWER_UP_US};
      4'd1:    p = '{e: 1'b0, nib: 4'd3, hold: PULSE_US};
      4'd2, 4'd4, 4'd6: p = '{e: 1'b1, nib: 4'd3, hold: PULSE_US};
      4'd3, 4'd5, 4'd7: p = '{e: 1'b0, nib: 4'd3, hold: INIT_GAP_US};
      4'd8:    p = '{e: 1'b1, nib: 4'd2, hold: PULSE_US};
      4'd9:    p = '{e: 1'b0, nib: 4'd2, hold: INIT_GAP_US};
      default: p = '{e: 1'b0, nib: 4'd0, hold: 16'd0};
    endcase
    return p;
  endfunction

endpackage

### src/clns_ctrl.sv
// Sequencing state machine: walks the power-up steps, the five steps of each byte and the bad-row error step.
module clns_ctrl (
  input  logic                clk,
  input  logic                rst,
  input  logic                s_tvalid,
  output logic                s_tready,
  input  clns_pkg::clns_stat_t stat,
  output clns_pkg::clns_cmd_t  cmd
);
  import clns_pkg::*;

  clns_state_t state, state_next;
  logic [3:0] pre_idx, pre_idx_next;
  logic [2:0] sub, sub_next;
  logic [1:0] sel, sel_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state   <= ST_IDLE;
      pre_idx <= '0;
      sub     <= '0;
      sel     <= '0;
    end else begin
      state   <= state_next;
      pre_idx <= pre_idx_next;
      sub     <= sub_next;
      sel     <= sel_next;
    end
  end

  always_comb begin
    state_next   = state;
    pre_idx_next = pre_idx;
    sub_next     = sub;
    sel_next     = sel;
    s_tready     = 1'b0;
    cmd          = '0;
    cmd.pre_idx  = pre_idx;
    cmd.sub      = sub;
    cmd.sel      = sel;
    case (state)
      ST_IDLE: begin
        s_tready = 1'b1;
        cmd.load = s_tvalid;
        if (s_tvalid) begin
          pre_idx_next = '0;
          sub_next     = '0;
          case (stat.kind)
            KIND_INIT: begin
              state_next = ST_PRE;
              sel_next   = 2'd0;
            end
            KIND_BYTE: begin
              state_next = ST_BYTE;
              sel_next   = SEL_LAST;
            end
            KIND_BAD: state_next = ST_ERR;
            default:  state_next = ST_IDLE;
          endcase
        end
      end
      ST_PRE: begin
        cmd.pre  = 1'b1;
        cmd.emit = stat.free;
        if (stat.free) begin
          if (pre_idx == PRE_LAST) begin
            state_next = ST_BYTE;
          end else begin
            pre_idx_next = pre_idx + 4'd1;
          end
        end
      end
      ST_BYTE: begin
        cmd.emit = stat.free;
        cmd.last = (sub == SUB_LAST) && (sel == SEL_LAST);
        if (stat.free) begin
          if (sub == SUB_LAST) begin
            sub_next = '0;
            if (sel == SEL_LAST) begin
              state_next = ST_IDLE;
            end else begin
              sel_next = sel + 2'd1;
            end
          end else begin
            sub_next = sub + 3'd1;
          end
        end
      end
      ST_ERR: begin
        cmd.err  = 1'b1;
        cmd.last = 1'b1;
        cmd.emit = stat.free;
        if (stat.free) state_next = ST_IDLE;
      end
      default: state_next = ST_IDLE;
    endcase
  end

endmodule

### src/clns_dp.sv
// Datapath: settings, display and entry bits, request latch, step builder and output register.
module clns_dp (
  input  logic                clk,
  input  logic                rst,
  input  logic [23:0]         s_tdata,
  input  logic [3:0]          s_tuser,
  input  logic                cfg_valid,
  input  logic [1:0]          cfg_index,
  input  logic [4:0]          cfg_data,
  input  clns_pkg::clns_cmd_t  cmd,
  output clns_pkg::clns_stat_t stat,
  output logic                m_tvalid,
  input  logic                m_tready,
  output logic [23:0]         m_tdata,
  output logic [0:0]          m_tuser,
  output logic                m_tlast
);
  import clns_pkg::*;

  logic [4:0] func_bits;
  logic [2:0] disp_init;
  logic [1:0] entry_init;
  logic [2:0] disp_bits;
  logic [1:0] entry_bits;
  logic       init_mode;
  logic       clear_mode;
  logic       rs;
  logic [7:0] req_byte;

  logic [3:0] opcode;
  logic [7:0] data_byte;
  logic [2:0] row_number;
  logic [6:0] column_number;
  logic       flag_value;
  logic       row_bad;
  logic [6:0] addr;
  logic [2:0] disp_new;
  logic [1:0] entry_new;
  logic [7:0] byte_new;

  logic [7:0] cur_byte;
  logic [3:0] nib;
  clns_pin_t  pin;
  logic       step_rs;

  assign opcode        = s_tuser;
  assign data_byte     = s_tdata[7:0];
  assign row_number    = s_tdata[10:8];
  assign column_number = s_tdata[17:11];
  assign flag_value    = s_tdata[18];

  assign row_bad = (row_number == 3'd0) || (row_number > ROW_LIMIT);
  assign addr    = row_base(2'(row_number - 3'd1)) + column_number;

  always_comb begin
    disp_new  = disp_bits;
    entry_new = entry_bits;
    byte_new  = data_byte;
    stat.free = !m_tvalid || m_tready;
    stat.kind = KIND_BYTE;
    case (opcode)
      OP_INIT:   stat.kind = KIND_INIT;
      OP_CMD, OP_DATA: byte_new = data_byte;
      OP_MOVE: begin
        byte_new = {1'b1, addr};
        if (row_bad) stat.kind = KIND_BAD;
      end
      OP_CLEAR:  byte_new = 8'h01;
      OP_ON, OP_CURSOR, OP_BLINK: begin
        disp_new[2'(OP_BLINK - opcode)] = flag_value;
        byte_new = {5'b00001, disp_new};
      end
      OP_DIR, OP_SCROLL: begin
        entry_new[1'(OP_SCROLL - opcode)] = flag_value;
        byte_new = {6'b000001, entry_new};
      end
      default:   stat.kind = KIND_NONE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      func_bits  <= 5'd8;
      disp_init  <= 3'd4;
      entry_init <= 2'd2;
      disp_bits  <= '0;
      entry_bits <= '0;
    end else begin
      if (cfg_valid) begin
        case (cfg_index)
          CFG_FUNC:  func_bits  <= cfg_data;
          CFG_DISP:  disp_init  <= cfg_data[2:0];
          CFG_ENTRY: entry_init <= cfg_data[1:0];
          default:   ;
        endcase
      end
      if (cmd.load) begin
        if (opcode == OP_INIT) begin
          disp_bits  <= disp_init;
          entry_bits <= entry_init;
        end else begin
          disp_bits  <= disp_new;
          entry_bits <= entry_new;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      init_mode  <= (opcode == OP_INIT);
      clear_mode <= (opcode == OP_INIT) || (opcode == OP_CLEAR);
      rs         <= (opcode == OP_DATA);
      req_byte   <= byte_new;
    end
  end

  always_comb begin
    cur_byte = req_byte;
    if (init_mode) begin
      case (cmd.sel)
        2'd0:    cur_byte = {3'b001, func_bits};
        2'd1:    cur_byte = {5'b00001, disp_bits};
        2'd2:    cur_byte = {6'b000001, entry_bits};
        default: cur_byte = 8'h01;
      endcase
    end
    nib = (cmd.sub < 3'd3) ? cur_byte[7:4] : cur_byte[3:0];
    step_rs = rs;
    if (cmd.err) begin
      pin     = '0;
      step_rs = 1'b0;
    end else if (cmd.pre) begin
      pin     = pre_step(cmd.pre_idx);
      step_rs = 1'b0;
    end else begin
      pin.e   = (cmd.sub == 3'd1) || (cmd.sub == 3'd3);
      pin.nib = nib;
      if (cmd.sub != SUB_LAST) pin.hold = PULSE_US;
      else if (cmd.sel == SEL_LAST && clear_mode) pin.hold = CLEAR_HOLD_US;
      else pin.hold = BYTE_GAP_US;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (cmd.emit) begin
      m_tvalid <= 1'b1;
    end else if (m_tready) begin
      m_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.emit) begin
      m_tdata <= {1'b0, pin.hold, pin.nib, pin.e, 1'b0, step_rs};
      m_tuser <= cmd.err;
      m_tlast <= cmd.last;
    end
  end

endmodule

### src/char_lcd_nibble_sequencer.sv
// Top level of the character LCD nibble sequencer.
// Requests arrive on the s_ channel (opcode in s_tuser) and leave as timed pin
// steps on the m_ channel; m_tlast marks the final step of a request and
// m_tuser flags a rejected cursor row. Settings are written on the cfg_
// channel, always ready, and must only change while the block is idle.
// A request is taken while the controller is idle; each of its steps is then
// registered in the output register before it appears. Steps leave one per
// cycle while m_tready is high: five per byte request, thirty for init, one
// for a bad row, none for unused opcodes. The controller steps through one pin
// state per cycle into the single output register while it is free, and takes
// no new request until it is back in idle after a request's last step.
// When the receiver stalls, the output register holds its step and the
// controller waits; nothing is dropped. Reset restores the default settings,
// clears display and entry bits and leaves the output empty.
module char_lcd_nibble_sequencer (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic [23:0] s_tdata,  // data_byte, row_number, column_number, flag_value, pad
  input  logic [3:0]  s_tuser,  // opcode
  output logic        m_tvalid,
  input  logic        m_tready,
  output logic [23:0] m_tdata,  // reg_select, read_write, enable_pin, data_nibble, hold_us, pad
  output logic [0:0]  m_tuser,  // status
  output logic        m_tlast,
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [1:0]  cfg_index,
  input  logic [4:0]  cfg_data
);
  import clns_pkg::*;

  clns_cmd_t  cmd;
  clns_stat_t stat;

  assign cfg_ready = 1'b1;

  clns_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .stat     (stat),
    .cmd      (cmd)
  );

  clns_dp u_dp (
    .clk       (clk),
    .rst       (rst),
    .s_tdata   (s_tdata),
    .s_tuser   (s_tuser),
    .cfg_valid (cfg_valid),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .cmd       (cmd),
    .stat      (stat),
    .m_tvalid  (m_tvalid),
    .m_tready  (m_tready),
    .m_tdata   (m_tdata),
    .m_tuser   (m_tuser),
    .m_tlast   (m_tlast)
  );

endmodule
